>>> hw/rtl/sth_pkg.sv
// types, constants and saturation helpers shared by the stokes heun step block
`timescale 1ns / 1ps

package sth_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [39:0] wide_t;

    typedef struct packed {
        logic [30:0] step_length;
        word_t       emit_i;
        word_t       emit_q;
        word_t       emit_u;
        word_t       emit_v;
        word_t       absorb_i;
        word_t       absorb_q;
        word_t       absorb_u;
        word_t       absorb_v;
        word_t       rotate_q;
        word_t       rotate_u;
        word_t       rotate_v;
    } step_t;

    typedef struct packed {
        word_t stokes_i_out;
        word_t stokes_q_out;
        word_t stokes_u_out;
        word_t stokes_v_out;
    } stokes_t;

    typedef enum logic [1:0] {
        PH_RATE0,
        PH_PRED,
        PH_RATE1,
        PH_CORR
    } phase_t;

    // travels alongside each product through the multiplier
    typedef struct packed {
        logic       vld;
        phase_t     phase;
        logic [1:0] comp;
        logic [1:0] term;
        logic       neg;
    } mul_tag_t;

    localparam int FRAC_BITS = 24;

    localparam wide_t WIDE_MAX = 40'sd2147483647;
    localparam wide_t WIDE_MIN = -40'sd2147483648;
    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    // coefficient codes
    localparam logic [2:0] CF_AI = 3'd0;
    localparam logic [2:0] CF_AQ = 3'd1;
    localparam logic [2:0] CF_AU = 3'd2;
    localparam logic [2:0] CF_AV = 3'd3;
    localparam logic [2:0] CF_RQ = 3'd4;
    localparam logic [2:0] CF_RU = 3'd5;
    localparam logic [2:0] CF_RV = 3'd6;

    // transfer matrix, indexed by {component, term}
    localparam logic [2:0] COEF_SEL [16] = '{
        CF_AI, CF_AQ, CF_AU, CF_AV,
        CF_AQ, CF_AI, CF_RV, CF_RU,
        CF_AU, CF_RV, CF_AI, CF_RQ,
        CF_AV, CF_RU, CF_RQ, CF_AI
    };

    // terms subtracted rather than added
    localparam logic [15:0] COEF_NEG = 16'h4280;

    function automatic wide_t sext(input word_t w);
        return {{8{w[31]}}, w};
    endfunction

    function automatic word_t sat32(input wide_t x);
        word_t r;
        if (x > WIDE_MAX)
        begin
            r = WORD_MAX;
        end
        else if (x < WIDE_MIN)
        begin
            r = WORD_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sth_qmul.sv
// shared q8.24 multiplier: registered product, then round half up and saturate
`timescale 1ns / 1ps

module sth_qmul
    import sth_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  word_t    a,
    input  word_t    b,
    input  mul_tag_t tag_in,
    output word_t    res,
    output mul_tag_t tag_out
);

    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;
    logic signed [63:0] rnd;
    mul_tag_t           tag1_reg;
    word_t              res_reg;
    mul_tag_t           tag2_reg;
    wide_t              shifted;

    // floor of the rounded product, upper bits kept for saturation
    assign rnd     = prod_reg + HALF_LSB;
    assign shifted = rnd[FRAC_BITS +: 40];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        res_reg  <= sat32(shifted);
    end

    assign res     = res_reg;
    assign tag_out = tag2_reg;

endmodule

>>> hw/rtl/stokes_transfer_heun_step.sv
// top level: heun step sequencer around one shared q8.24 multiplier
`timescale 1ns / 1ps

// channel   signals                                   direction
// step      step_valid, step_stall, step_data         in  (coefficients, step length)
// stokes    stokes_valid, stokes_stall, stokes_data   out (updated i, q, u, v)
//
// one item runs from acceptance until its result is shown, and no new item is
// taken before then; the next can be taken while that result is shown. the single
// 32x32 multiplier issues one product a cycle while the sequencer runs and is not
// waiting (40 products); it drains after each phase, then the output register loads.
// reset clears the stokes state to zero; every new ray must start with a reset, which the block does not enforce.
// a stalled result sits in the output register while the next item is accepted.

module stokes_transfer_heun_step
    import sth_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_valid,
    output logic    step_stall,
    input  step_t   step_data,
    output logic    stokes_valid,
    input  logic    stokes_stall,
    output stokes_t stokes_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    localparam logic [1:0] DRAIN_WAIT = 2'd3;

    state_t   state_reg,  state_next;
    phase_t   phase_reg,  phase_next;
    logic [3:0] cnt_reg,  cnt_next;
    logic [1:0] wait_reg, wait_next;
    step_t    item_reg,   item_next;
    word_t    s_reg  [4];
    word_t    s_next [4];
    word_t    st_reg  [4];
    word_t    st_next [4];
    word_t    r0_reg  [4];
    word_t    r0_next [4];
    word_t    rt_reg  [4];
    word_t    rt_next [4];
    logic signed [33:0] acc_reg, acc_next;
    word_t    a_reg,   a_next;
    word_t    b_reg,   b_next;
    mul_tag_t tag_reg, tag_next;
    stokes_t  out_reg, out_next;
    logic     out_vld_reg, out_vld_next;

    word_t    coef [7];
    word_t    emit [4];
    word_t    mul_res;
    mul_tag_t mul_tag;

    logic [1:0] k_rate;
    logic [1:0] t_rate;
    logic [1:0] k_lin;
    word_t    vec_sel;
    word_t    slope;
    word_t    mean;
    wide_t    mean_sum;
    word_t    step_w;
    logic     issue;
    logic     last;
    wide_t    p_w;
    wide_t    pe;
    wide_t    acc_sum;

    assign coef[0] = item_reg.absorb_i;
    assign coef[1] = item_reg.absorb_q;
    assign coef[2] = item_reg.absorb_u;
    assign coef[3] = item_reg.absorb_v;
    assign coef[4] = item_reg.rotate_q;
    assign coef[5] = item_reg.rotate_u;
    assign coef[6] = item_reg.rotate_v;

    assign emit[0] = item_reg.emit_i;
    assign emit[1] = item_reg.emit_q;
    assign emit[2] = item_reg.emit_u;
    assign emit[3] = item_reg.emit_v;

    assign k_rate = cnt_reg[3:2];
    assign t_rate = cnt_reg[1:0];
    assign k_lin  = cnt_reg[1:0];
    assign step_w = word_t'({1'b0, item_reg.step_length});
    assign issue  = (state_reg == ST_RUN) && (wait_reg == 2'd0);

    sth_qmul u_qmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .a       (a_reg),
        .b       (b_reg),
        .tag_in  (tag_reg),
        .res     (mul_res),
        .tag_out (mul_tag)
    );

    // operand selection for the next product
    always_comb
    begin
        vec_sel  = (phase_reg == PH_RATE0) ? s_reg[t_rate] : st_reg[t_rate];
        slope    = sat32(sext(emit[k_lin]) - sext(r0_reg[k_lin]));
        mean_sum = (sext(emit[k_lin]) <<< 1) - sext(r0_reg[k_lin])
                   - sext(rt_reg[k_lin]) + 40'sd1;
        mean     = sat32(mean_sum >>> 1);

        a_next   = a_reg;
        b_next   = b_reg;
        tag_next = '0;
        last     = 1'b0;
        unique case (phase_reg)
            PH_RATE0, PH_RATE1:
            begin
                a_next         = coef[COEF_SEL[cnt_reg]];
                b_next         = vec_sel;
                tag_next.comp  = k_rate;
                tag_next.term  = t_rate;
                tag_next.neg   = COEF_NEG[cnt_reg];
                last           = (cnt_reg == 4'd15);
            end
            PH_PRED:
            begin
                a_next         = step_w;
                b_next         = slope;
                tag_next.comp  = k_lin;
                last           = (cnt_reg == 4'd3);
            end
            PH_CORR:
            begin
                a_next         = step_w;
                b_next         = mean;
                tag_next.comp  = k_lin;
                last           = (cnt_reg == 4'd3);
            end
            default:
            begin
                last = 1'b0;
            end
        endcase
        tag_next.phase = phase_reg;
        tag_next.vld   = issue;
    end

    // sequencer, product writeback and output register
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        wait_next    = wait_reg;
        item_next    = item_reg;
        s_next       = s_reg;
        st_next      = st_reg;
        r0_next      = r0_reg;
        rt_next      = rt_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;

        p_w     = sext(mul_res);
        pe      = mul_tag.neg ? -p_w : p_w;
        acc_sum = {{6{acc_reg[33]}}, acc_reg} + pe;

        if (mul_tag.vld)
        begin
            unique case (mul_tag.phase)
                PH_RATE0, PH_RATE1:
                begin
                    if (mul_tag.term == 2'd0)
                    begin
                        acc_next = pe[33:0];
                    end
                    else
                    begin
                        acc_next = acc_sum[33:0];
                    end
                    if (mul_tag.term == 2'd3)
                    begin
                        if (mul_tag.phase == PH_RATE0)
                        begin
                            r0_next[mul_tag.comp] = sat32(acc_sum);
                        end
                        else
                        begin
                            rt_next[mul_tag.comp] = sat32(acc_sum);
                        end
                    end
                end
                PH_PRED:
                begin
                    st_next[mul_tag.comp] = sat32(sext(s_reg[mul_tag.comp]) + p_w);
                end
                PH_CORR:
                begin
                    s_next[mul_tag.comp] = sat32(sext(s_reg[mul_tag.comp]) + p_w);
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        if (out_vld_reg && !stokes_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_valid)
                begin
                    item_next  = step_data;
                    phase_next = PH_RATE0;
                    cnt_next   = 4'd0;
                    wait_next  = 2'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (wait_reg != 2'd0)
                begin
                    wait_next = wait_reg - 2'd1;
                end
                else if (last)
                begin
                    cnt_next  = 4'd0;
                    wait_next = DRAIN_WAIT;
                    unique case (phase_reg)
                        PH_RATE0: phase_next = PH_PRED;
                        PH_PRED:  phase_next = PH_RATE1;
                        PH_RATE1: phase_next = PH_CORR;
                        PH_CORR:  state_next = ST_DRAIN;
                        default:  phase_next = PH_RATE0;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_DRAIN:
            begin
                if (wait_reg != 2'd0)
                begin
                    wait_next = wait_reg - 2'd1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait until the previous result has been taken
                if (!out_vld_reg || !stokes_stall)
                begin
                    out_next.stokes_i_out = s_reg[0];
                    out_next.stokes_q_out = s_reg[1];
                    out_next.stokes_u_out = s_reg[2];
                    out_next.stokes_v_out = s_reg[3];
                    out_vld_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_RATE0;
            cnt_reg     <= 4'd0;
            wait_reg    <= 2'd0;
            tag_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            wait_reg    <= wait_next;
            tag_reg     <= tag_next;
            out_vld_reg <= out_vld_next;
            s_reg       <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        st_reg   <= st_next;
        r0_reg   <= r0_next;
        rt_reg   <= rt_next;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        out_reg  <= out_next;
    end

    assign step_stall   = (state_reg != ST_IDLE);
    assign stokes_valid = out_vld_reg;
    assign stokes_data  = out_reg;

endmodule

>>> test/stokes_transfer_heun_step_test.sv
// self-checking testbench for the stokes heun step block
`timescale 1ns / 1ps

module stokes_transfer_heun_step_test;
    import sth_pkg::*;

    localparam int IDLE_PCT = 18;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER_ITEMS = 300;
    localparam int TAIL_CYCLES = 60;
    localparam word_t ONE_Q = 32'sd16777216;
    localparam logic [30:0] STEP_ONE = 31'd16777216;
    localparam logic [30:0] STEP_MAX = 31'h7fffffff;

    typedef enum int {
        MIX_FULL,
        MIX_EXTREME,
        MIX_BOUNDED
    } mix_t;

    class stokes_scoreboard;
        longint ray_stokes[4];
        stokes_t expected_stokes[$];
        int mismatches;

        function new();
            int k;
            for (k = 0; k < 4; k++)
            begin
                ray_stokes[k] = 0;
            end
            mismatches = 0;
        endfunction

        function longint clamp_word(input longint x);
            longint r;
            r = x;
            if (x > 64'sd2147483647)
            begin
                r = 64'sd2147483647;
            end
            else if (x < -64'sd2147483648)
            begin
                r = -64'sd2147483648;
            end
            return r;
        endfunction

        // q8.24 product, half rounds towards plus infinity
        function longint qmul(input longint a, input longint b);
            longint p;
            p = a * b + (64'sd1 <<< 23);
            return clamp_word(p >>> 24);
        endfunction

        function void transfer_rate(input longint cf[7], input longint sv[4],
                                    output longint rate[4]);
            rate[0] = clamp_word(qmul(cf[CF_AI], sv[0]) + qmul(cf[CF_AQ], sv[1])
                               + qmul(cf[CF_AU], sv[2]) + qmul(cf[CF_AV], sv[3]));
            rate[1] = clamp_word(qmul(cf[CF_AQ], sv[0]) + qmul(cf[CF_AI], sv[1])
                               + qmul(cf[CF_RV], sv[2]) - qmul(cf[CF_RU], sv[3]));
            rate[2] = clamp_word(qmul(cf[CF_AU], sv[0]) - qmul(cf[CF_RV], sv[1])
                               + qmul(cf[CF_AI], sv[2]) + qmul(cf[CF_RQ], sv[3]));
            rate[3] = clamp_word(qmul(cf[CF_AV], sv[0]) + qmul(cf[CF_RU], sv[1])
                               - qmul(cf[CF_RQ], sv[2]) + qmul(cf[CF_AI], sv[3]));
        endfunction

        // advance the ray by one step and queue the stokes vector it should give
        function void note_step(input step_t s);
            longint d;
            longint em[4];
            longint cf[7];
            longint r0[4];
            longint rt[4];
            longint pred[4];
            longint mean;
            stokes_t e;
            int k;
            d = longint'(s.step_length);
            em[0] = longint'(s.emit_i);
            em[1] = longint'(s.emit_q);
            em[2] = longint'(s.emit_u);
            em[3] = longint'(s.emit_v);
            cf[CF_AI] = longint'(s.absorb_i);
            cf[CF_AQ] = longint'(s.absorb_q);
            cf[CF_AU] = longint'(s.absorb_u);
            cf[CF_AV] = longint'(s.absorb_v);
            cf[CF_RQ] = longint'(s.rotate_q);
            cf[CF_RU] = longint'(s.rotate_u);
            cf[CF_RV] = longint'(s.rotate_v);
            transfer_rate(cf, ray_stokes, r0);
            for (k = 0; k < 4; k++)
            begin
                pred[k] = clamp_word(ray_stokes[k] + qmul(d, clamp_word(em[k] - r0[k])));
            end
            transfer_rate(cf, pred, rt);
            for (k = 0; k < 4; k++)
            begin
                mean = clamp_word((2 * em[k] - r0[k] - rt[k] + 1) >>> 1);
                ray_stokes[k] = clamp_word(ray_stokes[k] + qmul(d, mean));
            end
            e.stokes_i_out = ray_stokes[0][31:0];
            e.stokes_q_out = ray_stokes[1][31:0];
            e.stokes_u_out = ray_stokes[2][31:0];
            e.stokes_v_out = ray_stokes[3][31:0];
            expected_stokes.push_back(e);
        endfunction

        function void check_word(input string name, input word_t want, input word_t got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_stokes(input stokes_t got);
            stokes_t want;
            if (expected_stokes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, got %h", $time, got);
            end
            else
            begin
                want = expected_stokes.pop_front();
                check_word("stokes_i_out", want.stokes_i_out, got.stokes_i_out);
                check_word("stokes_q_out", want.stokes_q_out, got.stokes_q_out);
                check_word("stokes_u_out", want.stokes_u_out, got.stokes_u_out);
                check_word("stokes_v_out", want.stokes_v_out, got.stokes_v_out);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    step_valid = 1'b0;
    logic    step_stall;
    step_t   step_data = '0;
    logic    stokes_valid;
    logic    stokes_stall = 1'b0;
    stokes_t stokes_data;

    stokes_scoreboard sb = new();
    int sent_count = 0;

    stokes_transfer_heun_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .step_data    (step_data),
        .stokes_valid (stokes_valid),
        .stokes_stall (stokes_stall),
        .stokes_data  (stokes_data)
    );

    always #4 clk = ~clk;

    task automatic send_step(input step_t s, input int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            step_valid <= 1'b0;
            @(posedge clk);
        end
        step_valid <= 1'b1;
        step_data  <= s;
        @(posedge clk);
        while (step_stall)
        begin
            @(posedge clk);
        end
        sb.note_step(s);
        sent_count++;
    endtask

    function automatic step_t uniform_step(input logic [30:0] d, input word_t e,
                                           input word_t c);
        step_t s;
        s.step_length = d;
        s.emit_i   = e;
        s.emit_q   = e;
        s.emit_u   = e;
        s.emit_v   = e;
        s.absorb_i = c;
        s.absorb_q = c;
        s.absorb_u = c;
        s.absorb_v = c;
        s.rotate_q = c;
        s.rotate_u = c;
        s.rotate_v = c;
        return s;
    endfunction

    function automatic word_t draw_word(input mix_t mix, input int unsigned mag);
        word_t w;
        if (mix == MIX_FULL)
        begin
            w = $urandom;
        end
        else if (mix == MIX_EXTREME)
        begin
            case ($urandom_range(4))
                0: w = WORD_MIN;
                1: w = WORD_MAX;
                2: w = '0;
                3: w = '1;
                default: w = ONE_Q;
            endcase
        end
        else
        begin
            w = int'($urandom_range(2 * mag)) - int'(mag);
        end
        return w;
    endfunction

    function automatic step_t random_step();
        step_t s;
        mix_t mix;
        int unsigned pick;
        pick = $urandom_range(99);
        s = '0;
        if (pick < 8)
        begin
            // outside the radiating region: state must pass through unchanged
            s.step_length = $urandom;
            return s;
        end
        mix = (pick < 14) ? MIX_FULL : (pick < 19) ? MIX_EXTREME : MIX_BOUNDED;
        if (mix == MIX_FULL)
        begin
            s.step_length = $urandom;
        end
        else if (mix == MIX_EXTREME)
        begin
            case ($urandom_range(3))
                0: s.step_length = '0;
                1: s.step_length = STEP_MAX;
                2: s.step_length = 31'd1;
                default: s.step_length = STEP_ONE;
            endcase
        end
        else
        begin
            s.step_length = $urandom_range(STEP_ONE);
        end
        // bounded items keep the ray away from saturation
        s.emit_i   = draw_word(mix, 1 << 24);
        s.emit_q   = draw_word(mix, 1 << 23);
        s.emit_u   = draw_word(mix, 1 << 23);
        s.emit_v   = draw_word(mix, 1 << 23);
        s.absorb_i = (mix == MIX_BOUNDED) ? word_t'($urandom_range(1 << 25))
                                          : draw_word(mix, 0);
        s.absorb_q = draw_word(mix, 1 << 23);
        s.absorb_u = draw_word(mix, 1 << 23);
        s.absorb_v = draw_word(mix, 1 << 23);
        s.rotate_q = draw_word(mix, 1 << 24);
        s.rotate_u = draw_word(mix, 1 << 24);
        s.rotate_v = draw_word(mix, 1 << 24);
        return s;
    endfunction

    task automatic run_directed();
        step_t s;
        // zero state, no coefficients
        send_step(uniform_step('0, '0, '0), IDLE_PCT);
        // pure emission
        s = uniform_step(STEP_ONE, '0, '0);
        s.emit_i = ONE_Q;
        s.emit_q = ONE_Q / 2;
        s.emit_u = -ONE_Q / 2;
        s.emit_v = ONE_Q / 4;
        send_step(s, IDLE_PCT);
        send_step(uniform_step(STEP_ONE, '0, '0), IDLE_PCT);
        // pure absorption with unit optical depth halves the state
        s = uniform_step(STEP_ONE, '0, '0);
        s.absorb_i = ONE_Q;
        send_step(s, IDLE_PCT);
        // faraday rotation only, mixes q and u
        s = uniform_step(STEP_ONE >> 1, '0, '0);
        s.rotate_v = ONE_Q;
        send_step(s, IDLE_PCT);
        // every coupling at once
        s = uniform_step(STEP_ONE >> 2, ONE_Q / 8, ONE_Q / 4);
        s.absorb_i = ONE_Q / 2;
        s.rotate_u = -ONE_Q / 2;
        send_step(s, IDLE_PCT);
        // zero step leaves the state alone whatever the coefficients
        send_step(uniform_step('0, WORD_MIN, WORD_MAX), IDLE_PCT);
        // saturation at both ends
        send_step(uniform_step(STEP_MAX, WORD_MAX, '0), IDLE_PCT);
        send_step(uniform_step(STEP_MAX, '0, '0), IDLE_PCT);
        send_step(uniform_step(STEP_MAX, WORD_MIN, '0), IDLE_PCT);
        send_step(uniform_step(STEP_MAX, WORD_MAX, WORD_MAX), IDLE_PCT);
        send_step(uniform_step(STEP_MAX, WORD_MIN, WORD_MIN), IDLE_PCT);
        send_step(uniform_step(STEP_MAX, '1, '1), IDLE_PCT);
        // drain back towards zero
        s = uniform_step(STEP_ONE, '0, '0);
        s.absorb_i = ONE_Q;
        repeat (3) send_step(s, IDLE_PCT);
        // negative absorption amplifies
        s = uniform_step(STEP_ONE, '0, '0);
        s.absorb_i = -ONE_Q;
        s.emit_i = ONE_Q;
        send_step(s, IDLE_PCT);
        // rounding of half an lsb, both signs
        s = uniform_step(31'd1, '0, '0);
        s.emit_i = 32'sd8388608;
        s.emit_q = -32'sd8388608;
        s.emit_u = 32'sd1;
        s.emit_v = 32'sd12582912;
        send_step(s, IDLE_PCT);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_step(random_step(), (n >= 700 && n < 1000) ? 0 : IDLE_PCT);
        end
        step_valid <= 1'b0;
        while (sb.expected_stokes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin : result_side
        int cycles;
        int hold_left;
        bit hold_done;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stokes_valid && !stokes_stall)
            begin
                sb.check_stokes(stokes_data);
            end
            cycles++;
            // long hold-off so the block fills and stalls its input
            if (!hold_done && sent_count >= HOLD_AFTER_ITEMS)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                stokes_stall <= 1'b1;
                hold_left--;
            end
            else if (cycles >= 40000 && cycles < 60000)
            begin
                stokes_stall <= 1'b0;
            end
            else
            begin
                stokes_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
